// ===== sv/edu_pkg.sv =====
package edu_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned SqBits     = 2 * SampleBits;
  localparam int unsigned AccBits    = 42;
  localparam int unsigned DistBits   = 21;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [AccBits-1:0] AccMax = {AccBits{1'b1}};

  typedef struct packed {
    logic signed [SampleBits-1:0] x_value;
    logic signed [SampleBits-1:0] y_value;
    logic                         last_coord;
  } edu_in_t;

  typedef struct packed {
    logic [DistBits-1:0] distance;
    logic                saturated;
  } edu_out_t;

  typedef struct packed {
    logic [AccBits-1:0] sum;
    logic               clip;
  } edu_acc_t;

endpackage

// ===== sv/euclidean_distance_unit.sv =====
// Euclidean distance between two vectors streamed one coordinate pair per request.
// Input channel (in_valid_i / in_ready_o / in_data_i): signed x and y coordinates
// and a last-coordinate mark. Output channel (out_valid_o / out_ready_i /
// out_data_o): floor square root of the summed squared differences and a flag
// set when the 42-bit accumulator clipped during that vector pair.
// Coordinates are taken one per cycle while in_ready_o is high: the squared
// difference is registered, then added into the accumulator. The last
// coordinate pushes the sum into a two-entry queue; the square root unit pops it
// and resolves one result bit per cycle until all 21 distance bits are found.
// It takes a new sum only when idle, once its last result has moved to the
// output register; long vectors stream at a full coordinate per cycle, while
// short ones stall the input once the queue is full.
// While the receiver stalls, the output register holds its result, the queue
// fills, and then in_ready_o drops on the next last coordinate.
// Reset (rst_ni low, asynchronous) clears the accumulator, the clip flag, the
// queue and the output valid.
module euclidean_distance_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  edu_pkg::edu_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output edu_pkg::edu_out_t out_data_o
);
  import edu_pkg::*;

  logic     push_valid;
  logic     push_ready;
  edu_acc_t push_data;
  logic     pop_valid;
  logic     pop_ready;
  edu_acc_t pop_data;

  edu_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_data_i    (in_data_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  edu_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  edu_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/edu_front.sv =====
module edu_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  edu_pkg::edu_in_t  in_data_i,
  output logic              push_valid_o,
  input  logic              push_ready_i,
  output edu_pkg::edu_acc_t push_data_o
);
  import edu_pkg::*;

  logic signed [SampleBits:0] diff;
  logic [SampleBits:0]        mag_wide;
  logic [SampleBits-1:0]      mag;
  logic [SqBits-1:0]          sq_d;

  logic                sq_valid_q;
  logic                sq_last_q;
  logic [SqBits-1:0]   sq_q;
  logic [AccBits-1:0]  acc_q;
  logic                clip_q;

  logic [AccBits:0]    sum_w;
  logic                over;
  logic [AccBits-1:0]  acc_next;
  logic                clip_next;
  logic                stall;

  assign diff     = {in_data_i.x_value[SampleBits-1], in_data_i.x_value}
                  - {in_data_i.y_value[SampleBits-1], in_data_i.y_value};
  assign mag_wide = diff[SampleBits] ? (~diff + 1'b1) : diff;
  assign mag      = mag_wide[SampleBits-1:0];
  assign sq_d     = mag * mag;

  assign sum_w     = {1'b0, acc_q} + {{(AccBits - SqBits + 1){1'b0}}, sq_q};
  assign over      = sum_w[AccBits];
  assign acc_next  = over ? AccMax : sum_w[AccBits-1:0];
  assign clip_next = clip_q | over;

  // hold the squared term while the last one of a vector waits for queue space
  assign stall        = sq_valid_q && sq_last_q && !push_ready_i;
  assign in_ready_o   = !stall;
  assign push_valid_o = sq_valid_q && sq_last_q;

  always_comb begin
    push_data_o      = '0;
    push_data_o.sum  = acc_next;
    push_data_o.clip = clip_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_valid_q <= 1'b0;
      acc_q      <= '0;
      clip_q     <= 1'b0;
    end else if (!stall) begin
      sq_valid_q <= in_valid_i;
      if (sq_valid_q) begin
        if (sq_last_q) begin
          acc_q  <= '0;
          clip_q <= 1'b0;
        end else begin
          acc_q  <= acc_next;
          clip_q <= clip_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall && in_valid_i) begin
      sq_q      <= sq_d;
      sq_last_q <= in_data_i.last_coord;
    end
  end

endmodule

// ===== sv/edu_fifo.sv =====
module edu_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  edu_pkg::edu_acc_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output edu_pkg::edu_acc_t pop_data_o
);
  import edu_pkg::*;

  edu_acc_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q;
  logic [QueuePtrW-1:0]   rd_ptr_q;
  logic [QueueCntW-1:0]   count_q;
  logic                   do_push;
  logic                   do_pop;

  assign push_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/edu_sqrt.sv =====
module edu_sqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  edu_pkg::edu_acc_t pop_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output edu_pkg::edu_out_t out_data_o
);
  import edu_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  localparam logic [AccBits-1:0] BitStart = AccBits'(1) << (2 * (DistBits - 1));

  logic [1:0]          state_q;
  logic [1:0]          state_d;
  logic [AccBits-1:0]  rem_q;
  logic [AccBits-1:0]  root_q;
  logic [AccBits-1:0]  bit_q;
  logic                clip_q;
  logic [AccBits-1:0]  trial;
  logic [AccBits-1:0]  rem_d;
  logic [AccBits-1:0]  root_d;
  logic [AccBits-1:0]  bit_d;
  logic                out_valid_q;
  edu_out_t            out_q;
  logic                slot_free;

  assign trial     = root_q + bit_q;
  assign bit_d     = bit_q >> 2;
  assign slot_free = !out_valid_q || out_ready_i;

  // one result bit per cycle, restoring square root
  always_comb begin
    if (rem_q >= trial) begin
      rem_d  = rem_q - trial;
      root_d = (root_q >> 1) + bit_q;
    end else begin
      rem_d  = rem_q;
      root_d = root_q >> 1;
    end
  end

  always_comb begin
    state_d     = state_q;
    pop_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) state_d = StRun;
      end
      StRun: begin
        if (bit_d == '0) state_d = StDone;
      end
      StDone: begin
        if (slot_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == StDone && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && pop_valid_i) begin
      rem_q  <= pop_data_i.sum;
      clip_q <= pop_data_i.clip;
      root_q <= '0;
      bit_q  <= BitStart;
    end else if (state_q == StRun) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      bit_q  <= bit_d;
    end
    if (state_q == StDone && slot_free) begin
      out_q.distance  <= root_q[DistBits-1:0];
      out_q.saturated <= clip_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
